FILE: sv/srfcs_pkg.sv
package srfcs_pkg;

   localparam int GRID_DIM   = 511;
   localparam int CENTER     = GRID_DIM / 2;
   localparam int CELL_COUNT = GRID_DIM * GRID_DIM;

   localparam int INDEX_W = 18;
   localparam int VALUE_W = 8;
   localparam int RING_W  = 9;
   localparam int OFS_W   = 9;
   localparam int RAM_AW  = $clog2(CELL_COUNT);
   localparam int COORD_W = $clog2(GRID_DIM) + 2;

   localparam logic [1:0] REQ_WR_VISITED = 2'd0;
   localparam logic [1:0] REQ_WR_COST    = 2'd1;
   localparam logic [1:0] REQ_SEARCH     = 2'd2;

   localparam logic [1:0] STATUS_WRITE_DONE = 2'd0;
   localparam logic [1:0] STATUS_FOUND      = 2'd1;
   localparam logic [1:0] STATUS_RING_EMPTY = 2'd2;
   localparam logic [1:0] STATUS_EXHAUSTED  = 2'd3;

   localparam logic [1:0] SIDE_RIGHT  = 2'd0;
   localparam logic [1:0] SIDE_TOP    = 2'd1;
   localparam logic [1:0] SIDE_LEFT   = 2'd2;
   localparam logic [1:0] SIDE_BOTTOM = 2'd3;

   localparam logic signed [VALUE_W-1:0] THRESH_RESET = VALUE_W'(50);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_WALK  = 3'b100
   } state_type;

endpackage

FILE: sv/srfcs_ram.sv
module srfcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/square_ring_free_cell_search.sv
// Square ring free cell search.
// Request channel (req_valid / req_stall) carries a request type, a linear cell
// index and a signed cell value; one transfer happens when req_valid is high and
// req_stall is low. Result channel (rsp_valid / rsp_stall) returns exactly one
// result per request: status, found index, column and row offsets, ring side
// and ring radius. csr_write loads the signed cost threshold from csr_wdata.
// Writes of either map (and undefined request types) give their result in the
// cycle after the transfer. A search visits one ring cell per cycle through a
// three stage walk (coordinate and address, map read, check) until a hit or
// the end of the ring; an exhausted search answers like a write. The single
// map read port of each memory sets that rate. Only one request is in work at
// a time; a finished result sits in the output register and the next request
// is taken as soon as that register is empty or being drained. After reset
// both maps are cleared one cell per cycle, all 261121 cells, with req_stall
// held high; threshold writes are taken during the clearing pass. While
// rsp_stall is high a pending result holds and new requests are stalled.
module square_ring_free_cell_search (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic signed [srfcs_pkg::VALUE_W-1:0]  csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_type,
   input  logic [srfcs_pkg::INDEX_W-1:0]         req_cell_index,
   input  logic signed [srfcs_pkg::VALUE_W-1:0]  req_cell_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [srfcs_pkg::INDEX_W-1:0]         rsp_found_index,
   output logic signed [srfcs_pkg::OFS_W-1:0]    rsp_col_offset,
   output logic signed [srfcs_pkg::OFS_W-1:0]    rsp_row_offset,
   output logic [1:0]                            rsp_ring_side,
   output logic [srfcs_pkg::RING_W-1:0]          rsp_ring_radius
);

   localparam int CW = srfcs_pkg::COORD_W;
   localparam int AW = srfcs_pkg::RAM_AW;
   localparam int IW = srfcs_pkg::INDEX_W;
   localparam int VW = srfcs_pkg::VALUE_W;
   localparam int RW = srfcs_pkg::RING_W;
   localparam int OW = srfcs_pkg::OFS_W;
   localparam logic signed [CW-1:0] CTR_C = CW'(srfcs_pkg::CENTER);
   localparam logic signed [CW-1:0] DIM_C = CW'(srfcs_pkg::GRID_DIM);

   srfcs_pkg::state_type state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic signed [VW-1:0] thresh_ff;
   logic [RW-1:0]        ring_ff, ring_in;
   logic [1:0]           cside_ff, cside_in;
   logic signed [CW-1:0] roff_ff, roff_in;
   logic                 fresh_ff, fresh_in;

   logic                 gen_act_ff, gen_act_in;
   logic [1:0]           gen_side_ff, gen_side_in;
   logic signed [CW-1:0] gen_off_ff, gen_off_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_inr_ff, s1_inr_in;
   logic [IW-1:0]        s1_idx_ff, s1_idx_in;
   logic [1:0]           s1_side_ff, s1_side_in;
   logic signed [CW-1:0] s1_off_ff, s1_off_in;
   logic signed [OW-1:0] s1_cofs_ff, s1_cofs_in;
   logic signed [OW-1:0] s1_rofs_ff, s1_rofs_in;

   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_inr_ff, s2_inr_in;
   logic [IW-1:0]        s2_idx_ff, s2_idx_in;
   logic [1:0]           s2_side_ff, s2_side_in;
   logic signed [CW-1:0] s2_off_ff, s2_off_in;
   logic signed [OW-1:0] s2_cofs_ff, s2_cofs_in;
   logic signed [OW-1:0] s2_rofs_ff, s2_rofs_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [IW-1:0]        rsp_idx_ff, rsp_idx_in;
   logic signed [OW-1:0] rsp_cofs_ff, rsp_cofs_in;
   logic signed [OW-1:0] rsp_rofs_ff, rsp_rofs_in;
   logic [1:0]           rsp_side_ff, rsp_side_in;
   logic [RW-1:0]        rsp_radius_ff, rsp_radius_in;

   logic                 req_take;
   logic                 hit;
   logic signed [CW-1:0] d_s;
   logic signed [CW-1:0] row;
   logic signed [CW-1:0] col;
   logic signed [CW-1:0] off_nx;
   logic                 inr;
   logic [IW-1:0]        idx_calc;

   logic                 vis_we, cost_we;
   logic [AW-1:0]        wr_addr;
   logic [VW-1:0]        wr_data;
   logic [VW-1:0]        vis_rd, cost_rd;

   srfcs_ram #(.WIDTH(VW), .DEPTH(srfcs_pkg::CELL_COUNT)) u_visited (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (s1_valid_ff),
      .rd_addr (s1_idx_ff[AW-1:0]),
      .rd_data (vis_rd)
   );

   srfcs_ram #(.WIDTH(VW), .DEPTH(srfcs_pkg::CELL_COUNT)) u_cost (
      .clock   (clock),
      .wr_en   (cost_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (s1_valid_ff),
      .rd_addr (s1_idx_ff[AW-1:0]),
      .rd_data (cost_rd)
   );

   assign req_stall = (state_ff != srfcs_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign d_s       = $signed({{(CW-RW){1'b0}}, ring_ff});
   assign off_nx    = gen_off_ff + CW'(1);
   assign hit       = s2_valid_ff && s2_inr_ff && (vis_rd == '0)
                      && ($signed(cost_rd) < thresh_ff);

   // ring cell coordinates for the current walk position
   always_comb begin
      case (gen_side_ff)
         srfcs_pkg::SIDE_RIGHT: begin
            row = CTR_C - gen_off_ff;
            col = CTR_C + d_s;
         end
         srfcs_pkg::SIDE_TOP: begin
            row = CTR_C - d_s;
            col = CTR_C - gen_off_ff;
         end
         srfcs_pkg::SIDE_LEFT: begin
            row = CTR_C + gen_off_ff;
            col = CTR_C - d_s;
         end
         default: begin
            row = CTR_C + d_s;
            col = CTR_C + gen_off_ff;
         end
      endcase
      inr = (row >= 0) && (row < DIM_C) && (col >= 0) && (col < DIM_C);
      idx_calc = IW'($unsigned(row)) * IW'(srfcs_pkg::GRID_DIM) + IW'($unsigned(col));
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ring_in       = ring_ff;
      cside_in      = cside_ff;
      roff_in       = roff_ff;
      fresh_in      = fresh_ff;
      gen_act_in    = gen_act_ff;
      gen_side_in   = gen_side_ff;
      gen_off_in    = gen_off_ff;
      s1_valid_in   = s1_valid_ff;
      s1_inr_in     = s1_inr_ff;
      s1_idx_in     = s1_idx_ff;
      s1_side_in    = s1_side_ff;
      s1_off_in     = s1_off_ff;
      s1_cofs_in    = s1_cofs_ff;
      s1_rofs_in    = s1_rofs_ff;
      s2_valid_in   = s2_valid_ff;
      s2_inr_in     = s2_inr_ff;
      s2_idx_in     = s2_idx_ff;
      s2_side_in    = s2_side_ff;
      s2_off_in     = s2_off_ff;
      s2_cofs_in    = s2_cofs_ff;
      s2_rofs_in    = s2_rofs_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_cofs_in   = rsp_cofs_ff;
      rsp_rofs_in   = rsp_rofs_ff;
      rsp_side_in   = rsp_side_ff;
      rsp_radius_in = rsp_radius_ff;
      vis_we        = 1'b0;
      cost_we       = 1'b0;
      wr_addr       = req_cell_index[AW-1:0];
      wr_data       = req_cell_value;

      case (state_ff)
         srfcs_pkg::ST_CLEAR: begin
            vis_we  = 1'b1;
            cost_we = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(srfcs_pkg::CELL_COUNT - 1)) begin
               state_in = srfcs_pkg::ST_IDLE;
            end
         end
         srfcs_pkg::ST_IDLE: begin
            if (req_take) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = srfcs_pkg::STATUS_WRITE_DONE;
               rsp_idx_in    = '0;
               rsp_cofs_in   = '0;
               rsp_rofs_in   = '0;
               rsp_side_in   = srfcs_pkg::SIDE_RIGHT;
               rsp_radius_in = ring_ff;
               case (req_type)
                  srfcs_pkg::REQ_WR_VISITED: begin
                     vis_we = (req_cell_index < IW'(srfcs_pkg::CELL_COUNT));
                  end
                  srfcs_pkg::REQ_WR_COST: begin
                     cost_we = (req_cell_index < IW'(srfcs_pkg::CELL_COUNT));
                  end
                  srfcs_pkg::REQ_SEARCH: begin
                     if (ring_ff > RW'(srfcs_pkg::CENTER)) begin
                        rsp_status_in = srfcs_pkg::STATUS_EXHAUSTED;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = srfcs_pkg::ST_WALK;
                        gen_act_in   = 1'b1;
                        gen_side_in  = cside_ff;
                        if (fresh_ff || (roff_ff < -d_s)) begin
                           gen_off_in = -d_s;
                        end else begin
                           gen_off_in = roff_ff;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = srfcs_pkg::STATUS_WRITE_DONE;
                  end
               endcase
            end
         end
         srfcs_pkg::ST_WALK: begin
            if (hit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = srfcs_pkg::STATUS_FOUND;
               rsp_idx_in    = s2_idx_ff;
               rsp_cofs_in   = s2_cofs_ff;
               rsp_rofs_in   = s2_rofs_ff;
               rsp_side_in   = s2_side_ff;
               rsp_radius_in = ring_ff;
               cside_in      = s2_side_ff;
               roff_in       = s2_off_ff;
               fresh_in      = 1'b0;
               gen_act_in    = 1'b0;
               s1_valid_in   = 1'b0;
               s2_valid_in   = 1'b0;
               state_in      = srfcs_pkg::ST_IDLE;
            end else if (!gen_act_ff && !s1_valid_ff && !s2_valid_ff) begin
               // ring empty: grow and restart at the first side
               ring_in       = ring_ff + RW'(2);
               cside_in      = srfcs_pkg::SIDE_RIGHT;
               roff_in       = '0;
               fresh_in      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = srfcs_pkg::STATUS_RING_EMPTY;
               rsp_idx_in    = '0;
               rsp_cofs_in   = '0;
               rsp_rofs_in   = '0;
               rsp_side_in   = srfcs_pkg::SIDE_RIGHT;
               rsp_radius_in = ring_ff + RW'(2);
               state_in      = srfcs_pkg::ST_IDLE;
            end else begin
               s2_valid_in = s1_valid_ff;
               s2_inr_in   = s1_inr_ff;
               s2_idx_in   = s1_idx_ff;
               s2_side_in  = s1_side_ff;
               s2_off_in   = s1_off_ff;
               s2_cofs_in  = s1_cofs_ff;
               s2_rofs_in  = s1_rofs_ff;
               s1_valid_in = gen_act_ff;
               s1_inr_in   = inr;
               s1_idx_in   = idx_calc;
               s1_side_in  = gen_side_ff;
               s1_off_in   = gen_off_ff;
               s1_cofs_in  = OW'(col - CTR_C);
               s1_rofs_in  = OW'(CTR_C - row);
               if (gen_act_ff) begin
                  if (off_nx == d_s) begin
                     if (gen_side_ff == srfcs_pkg::SIDE_BOTTOM) begin
                        gen_act_in = 1'b0;
                     end else begin
                        gen_side_in = gen_side_ff + 2'd1;
                        gen_off_in  = -d_s;
                     end
                  end else begin
                     gen_off_in = off_nx;
                  end
               end
            end
         end
         default: begin
            state_in = srfcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srfcs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         thresh_ff    <= srfcs_pkg::THRESH_RESET;
         ring_ff      <= RW'(1);
         cside_ff     <= srfcs_pkg::SIDE_RIGHT;
         roff_ff      <= '0;
         fresh_ff     <= 1'b1;
         gen_act_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         if (csr_write) begin
            thresh_ff <= csr_wdata;
         end
         ring_ff      <= ring_in;
         cside_ff     <= cside_in;
         roff_ff      <= roff_in;
         fresh_ff     <= fresh_in;
         gen_act_ff   <= gen_act_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gen_side_ff   <= gen_side_in;
      gen_off_ff    <= gen_off_in;
      s1_inr_ff     <= s1_inr_in;
      s1_idx_ff     <= s1_idx_in;
      s1_side_ff    <= s1_side_in;
      s1_off_ff     <= s1_off_in;
      s1_cofs_ff    <= s1_cofs_in;
      s1_rofs_ff    <= s1_rofs_in;
      s2_inr_ff     <= s2_inr_in;
      s2_idx_ff     <= s2_idx_in;
      s2_side_ff    <= s2_side_in;
      s2_off_ff     <= s2_off_in;
      s2_cofs_ff    <= s2_cofs_in;
      s2_rofs_ff    <= s2_rofs_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_cofs_ff   <= rsp_cofs_in;
      rsp_rofs_ff   <= rsp_rofs_in;
      rsp_side_ff   <= rsp_side_in;
      rsp_radius_ff <= rsp_radius_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_idx_ff;
   assign rsp_col_offset  = rsp_cofs_ff;
   assign rsp_row_offset  = rsp_rofs_ff;
   assign rsp_ring_side   = rsp_side_ff;
   assign rsp_ring_radius = rsp_radius_ff;

   a_walk_only_in_walk: assert property (@(posedge clock) disable iff (reset)
      (gen_act_ff || s1_valid_ff || s2_valid_ff) |-> (state_ff == srfcs_pkg::ST_WALK))
      else $error("walk pipeline busy outside walk state");

   a_slot_free_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srfcs_pkg::ST_WALK) |-> !rsp_valid_ff)
      else $error("result register occupied during a walk");

   a_hit_reported: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == srfcs_pkg::ST_WALK) && hit)
      |=> (rsp_valid_ff && (rsp_status_ff == srfcs_pkg::STATUS_FOUND)))
      else $error("hit not reported as found");

   a_offset_in_ring: assert property (@(posedge clock) disable iff (reset)
      gen_act_ff |-> ((gen_off_ff >= -d_s) && (gen_off_ff < d_s)))
      else $error("walk offset outside ring side");

endmodule
